// ===== hw/rtl/smss_pkg.sv =====
// Shared types and constants for the sorted matrix staircase search block.
package smss_pkg;

   localparam int ROW_W     = 4;
   localparam int COL_W     = 4;
   localparam int DATA_W    = 32;
   localparam int CFG_W     = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 2'd1;

   localparam logic [CFG_W-1:0] ROWS_IN_USE_RESET = 5'd16;
   localparam logic [CFG_W-1:0] COLS_IN_USE_RESET = 5'd16;

   typedef struct packed {
      logic             found;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } smss_res_type;

endpackage

// ===== hw/rtl/smss_mem.sv =====
// Matrix storage: one write port, one read port with registered read data.
module smss_mem #(
   parameter int DEPTH = 256
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic signed [smss_pkg::DATA_W-1:0]             wr_data,
   input  logic                                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic signed [smss_pkg::DATA_W-1:0]             rd_data_ff
);

   logic signed [smss_pkg::DATA_W-1:0] store_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/smss_walk.sv =====
// Staircase walk controller: issues one matrix read per cycle and steps left or down.
module smss_walk #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  logic                                                         clock,
   input  logic                                                         reset,
   input  logic                                                         start,
   input  logic signed [smss_pkg::DATA_W-1:0]                           key,
   input  logic [smss_pkg::CFG_W-1:0]                                   rows_cfg,
   input  logic [smss_pkg::CFG_W-1:0]                                   cols_cfg,
   input  logic                                                         slot_free,
   input  logic signed [smss_pkg::DATA_W-1:0]                           rd_data,
   output logic                                                         rd_en,
   output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] rd_addr,
   output logic                                                         busy,
   output logic                                                         res_push,
   output smss_pkg::smss_res_type                                       res_ff
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW    = $clog2(MAX_ROWS + 1);
   localparam int YW    = $clog2(MAX_COLS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                         state_ff, state_in;
   logic [XW-1:0]                      x_ff, x_in;
   logic [YW-1:0]                      y_ff, y_in;
   logic signed [smss_pkg::DATA_W-1:0] key_ff, key_in;
   smss_pkg::smss_res_type             res_in;
   logic [XW-1:0]                      rows_eff;
   logic [YW-1:0]                      cols_eff;
   logic [XW-1:0]                      x_next;
   logic [YW-1:0]                      col_cur;
   logic [XW+3:0]                      x_wide;
   logic [YW+3:0]                      col_wide;

   function automatic logic [AW-1:0] rc_addr(input logic [XW-1:0] r, input logic [YW-1:0] c);
      logic [31:0] a;
      a = 32'(r) * 32'(MAX_COLS) + 32'(c);
      return a[AW-1:0];
   endfunction

   always_comb begin
      if (32'(rows_cfg) > 32'(MAX_ROWS)) begin
         rows_eff = XW'(MAX_ROWS);
      end else begin
         rows_eff = XW'(rows_cfg);
      end
      if (32'(cols_cfg) > 32'(MAX_COLS)) begin
         cols_eff = YW'(MAX_COLS);
      end else begin
         cols_eff = YW'(cols_cfg);
      end
   end

   assign x_next   = XW'(x_ff + 1'b1);
   assign col_cur  = YW'(y_ff - 1'b1);
   assign x_wide   = (XW+4)'(x_ff);
   assign col_wide = (YW+4)'(col_cur);

   assign busy     = (state_ff != S_IDLE);
   assign res_push = (state_ff == S_DONE) && slot_free;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      key_in   = key_ff;
      res_in   = res_ff;
      rd_en    = 1'b0;
      rd_addr  = rc_addr(x_ff, col_cur);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in     = key;
               x_in       = '0;
               y_in       = cols_eff;
               res_in     = '0;
               if ((rows_eff == '0) || (cols_eff == '0)) begin
                  state_in = S_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = rc_addr('0, YW'(cols_eff - 1'b1));
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            // rd_data holds the entry at row x, column y-1
            if (rd_data == key_ff) begin
               res_in.found = 1'b1;
               res_in.row   = x_wide[3:0];
               res_in.col   = col_wide[3:0];
               state_in     = S_DONE;
            end else if (rd_data > key_ff) begin
               if (y_ff == YW'(1)) begin
                  state_in = S_DONE;
               end else begin
                  y_in    = col_cur;
                  rd_en   = 1'b1;
                  rd_addr = rc_addr(x_ff, YW'(y_ff - 2'd2));
               end
            end else begin
               if (x_next == rows_eff) begin
                  state_in = S_DONE;
               end else begin
                  x_in    = x_next;
                  rd_en   = 1'b1;
                  rd_addr = rc_addr(x_next, col_cur);
               end
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      key_ff <= key_in;
      res_ff <= res_in;
   end

endmodule

// ===== hw/rtl/sorted_matrix_staircase_search.sv =====
// Searches a row- and column-sorted matrix of signed 32-bit entries by a staircase walk
// from the top-right corner of the region in use. A write transaction (cmd 0) stores one
// entry and returns nothing. A search (cmd 1) on a nonempty region starts by reading that corner,
// then steps left or down through at most rows_in_use + cols_in_use - 1 entries and
// hands the result to the output register. The walk is paced by the single read port
// of the matrix memory, which returns one registered word per cycle. One transaction
// is worked on at a time; a result waiting on rsp_tready in the output register does
// not block a following write, but a finished search that cannot yet enter it does.
// The matrix has no reset; entries must be written before a search reaches them.
module sorted_matrix_staircase_search #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // entry_row[3:0], entry_col[7:4], entry_value[39:8], search_key[71:40]
   input  logic [71:0]                           req_tdata,
   // cmd[0]
   input  logic [0:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // found_row[3:0], found_col[7:4]
   output logic [7:0]                            rsp_tdata,
   // found[0]
   output logic [0:0]                            rsp_tuser,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [smss_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [smss_pkg::CFG_W-1:0]            csr_data
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [smss_pkg::CFG_W-1:0]         rows_cfg_ff, rows_cfg_in;
   logic [smss_pkg::CFG_W-1:0]         cols_cfg_ff, cols_cfg_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   smss_pkg::smss_res_type             rsp_res_ff;

   logic                               req_fire;
   logic                               req_cmd;
   logic [smss_pkg::ROW_W-1:0]         entry_row;
   logic [smss_pkg::COL_W-1:0]         entry_col;
   logic signed [smss_pkg::DATA_W-1:0] entry_value;
   logic signed [smss_pkg::DATA_W-1:0] search_key;
   logic [31:0]                        wr_addr_full;
   logic                               wr_en;
   logic [AW-1:0]                      wr_addr;
   logic                               rd_en;
   logic [AW-1:0]                      rd_addr;
   logic signed [smss_pkg::DATA_W-1:0] rd_data;
   logic                               busy;
   logic                               slot_free;
   logic                               res_push;
   smss_pkg::smss_res_type             walk_res;

   assign req_cmd     = req_tuser[0];
   assign entry_row   = req_tdata[3:0];
   assign entry_col   = req_tdata[7:4];
   assign entry_value = $signed(req_tdata[39:8]);
   assign search_key  = $signed(req_tdata[71:40]);

   assign req_tready = !busy;
   assign req_fire   = req_tvalid && req_tready;

   // out-of-range writes are dropped
   assign wr_addr_full = 32'(entry_row) * 32'(MAX_COLS) + 32'(entry_col);
   assign wr_addr      = wr_addr_full[AW-1:0];
   assign wr_en        = req_fire && (req_cmd == smss_pkg::CMD_WRITE)
                         && (32'(entry_row) < 32'(MAX_ROWS))
                         && (32'(entry_col) < 32'(MAX_COLS));

   assign slot_free = !rsp_valid_ff || rsp_tready;

   smss_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (entry_value),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   smss_walk #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .start     (req_fire && (req_cmd == smss_pkg::CMD_SEARCH)),
      .key       (search_key),
      .rows_cfg  (rows_cfg_ff),
      .cols_cfg  (cols_cfg_ff),
      .slot_free (slot_free),
      .rd_data   (rd_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .busy      (busy),
      .res_push  (res_push),
      .res_ff    (walk_res)
   );

   assign csr_ready = 1'b1;

   always_comb begin
      rows_cfg_in = rows_cfg_ff;
      cols_cfg_in = cols_cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            smss_pkg::CSR_ROWS_IN_USE: rows_cfg_in = csr_data;
            smss_pkg::CSR_COLS_IN_USE: cols_cfg_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff  <= smss_pkg::ROWS_IN_USE_RESET;
         cols_cfg_ff  <= smss_pkg::COLS_IN_USE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rsp_res_ff <= walk_res;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_res_ff.col, rsp_res_ff.row};
   assign rsp_tuser[0] = rsp_res_ff.found;

endmodule

// ===== dv/sorted_matrix_staircase_search_test.sv =====
// Self-checking testbench for the sorted matrix staircase search block.
`timescale 1ns / 1ps

module sorted_matrix_staircase_search_test;

   localparam int ROW_W     = smss_pkg::ROW_W;
   localparam int COL_W     = smss_pkg::COL_W;
   localparam int DATA_W    = smss_pkg::DATA_W;
   localparam int CFG_W     = smss_pkg::CFG_W;
   localparam int CSR_IDX_W = smss_pkg::CSR_IDX_W;

   localparam int GRID_ROWS     = 16;
   localparam int GRID_COLS     = 16;
   localparam int SETTLE_CYCLES = 40;    // full 16x16 walk plus margin
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int STALL_LIMIT   = 2000;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 2'd3;

   localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   // predicts search outcomes from its own copy of matrix and region registers
   class staircase_scoreboard;
      logic signed [DATA_W-1:0] grid [GRID_ROWS][GRID_COLS];
      logic [CFG_W-1:0] rows_cfg;
      logic [CFG_W-1:0] cols_cfg;
      smss_pkg::smss_res_type pending_q[$];
      int errors;

      function new();
         rows_cfg = smss_pkg::ROWS_IN_USE_RESET;
         cols_cfg = smss_pkg::COLS_IN_USE_RESET;
         errors = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         case (idx)
            smss_pkg::CSR_ROWS_IN_USE: rows_cfg = val;
            smss_pkg::CSR_COLS_IN_USE: cols_cfg = val;
            default: ;
         endcase
      endfunction

      function smss_pkg::smss_res_type walk(logic signed [DATA_W-1:0] key);
         smss_pkg::smss_res_type res;
         int rows;
         int cols;
         int x;
         int y;
         rows = (rows_cfg > GRID_ROWS) ? GRID_ROWS : rows_cfg;
         cols = (cols_cfg > GRID_COLS) ? GRID_COLS : cols_cfg;
         res = '0;
         x = 0;
         y = cols;   // y-1 is the current column
         while (x < rows && y > 0) begin
            if (grid[x][y-1] > key) begin
               y--;
            end else if (grid[x][y-1] < key) begin
               x++;
            end else begin
               res.found = 1'b1;
               res.row = ROW_W'(x);
               res.col = COL_W'(y - 1);
               break;
            end
         end
         return res;
      endfunction

      function void note_request(logic cmd, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                 logic signed [DATA_W-1:0] value,
                                 logic signed [DATA_W-1:0] key);
         if (cmd == smss_pkg::CMD_WRITE) begin
            grid[r][c] = value;
         end else begin
            pending_q.push_back(walk(key));
         end
      endfunction

      function void check_result(logic found, logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
         smss_pkg::smss_res_type want;
         if (pending_q.size() == 0) begin
            $error("unexpected result: found %0d row %0d col %0d", found, row, col);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            errors++;
         end
         if (row !== want.row) begin
            $error("found_row: expected %0d, actual %0d", want.row, row);
            errors++;
         end
         if (col !== want.col) begin
            $error("found_col: expected %0d, actual %0d", want.col, col);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [71:0] req_tdata = '0;    // entry_row[3:0], entry_col[7:4], entry_value[39:8],
                                   // search_key[71:40]
   logic [0:0] req_tuser = '0;     // cmd[0]
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // found_row[3:0], found_col[7:4]
   logic [0:0] rsp_tuser;          // found[0]
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_data = '0;

   staircase_scoreboard sb = new();
   logic signed [DATA_W-1:0] shadow [GRID_ROWS][GRID_COLS];   // generator's view of the matrix
   int gen_rows = GRID_ROWS;
   int gen_cols = GRID_COLS;
   bit no_idle = 1'b0;
   bit rsp_hold_req = 1'b0;
   int stall_cycles = 0;

   sorted_matrix_staircase_search #(
      .MAX_ROWS(GRID_ROWS),
      .MAX_COLS(GRID_COLS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // transaction monitors
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tuser[0], req_tdata[3:0], req_tdata[7:4], req_tdata[39:8],
                            req_tdata[71:40]);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tuser[0], rsp_tdata[3:0], rsp_tdata[7:4]);
         end
         if (csr_valid && csr_ready) begin
            sb.write_register(csr_index, csr_data);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $error("no progress, %0d results outstanding", sb.pending_q.size());
         $display("status: fail");
         $finish;
      end
   end

   function automatic int idle_len();
      int p;
      if (no_idle) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 85) return $urandom_range(1, 2);
      if (p < 96) return $urandom_range(3, 10);
      return $urandom_range(20, 60);
   endfunction

   // result sink with random back-pressure and one long hold on request
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else begin
            n = idle_len();
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // valid stays high after the transaction; the next call or drain() decides
   task send_req(logic cmd, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                 logic signed [DATA_W-1:0] value, logic signed [DATA_W-1:0] key);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {key, value, c, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task send_write(int r, int c, logic signed [DATA_W-1:0] value);
      shadow[r][c] = value;
      send_req(smss_pkg::CMD_WRITE, ROW_W'(r), COL_W'(c), value, $urandom());
   endtask

   task send_search(logic signed [DATA_W-1:0] key);
      send_req(smss_pkg::CMD_SEARCH, ROW_W'($urandom_range(0, 15)),
               COL_W'($urandom_range(0, 15)), $urandom(), key);
   endtask

   task drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task set_region(int rows, int cols);
      drain();
      write_csr(smss_pkg::CSR_ROWS_IN_USE, CFG_W'(rows));
      write_csr(smss_pkg::CSR_COLS_IN_USE, CFG_W'(cols));
      // key picking needs a nonempty range even when the region is empty
      gen_rows = (rows == 0 || rows > GRID_ROWS) ? GRID_ROWS : rows;
      gen_cols = (cols == 0 || cols > GRID_COLS) ? GRID_COLS : cols;
   endtask

   // fills every entry, nondecreasing along rows and columns, with runs of duplicates
   task load_sorted();
      longint v;
      for (int r = 0; r < GRID_ROWS; r++) begin
         for (int c = 0; c < GRID_COLS; c++) begin
            v = KEY_MIN;
            if (r > 0 && shadow[r-1][c] > v) v = shadow[r-1][c];
            if (c > 0 && shadow[r][c-1] > v) v = shadow[r][c-1];
            if ((r != 0 || c != 0) && $urandom_range(0, 3) != 0)
               v += $urandom_range(1, 1 << 27);
            if (v > KEY_MAX) v = KEY_MAX;
            send_write(r, c, v[31:0]);
         end
      end
   endtask

   // rewrites one entry with a value that keeps its row and column in order
   task sorted_write();
      int r;
      int c;
      longint lo;
      longint hi;
      longint v;
      r = $urandom_range(0, GRID_ROWS - 1);
      c = $urandom_range(0, GRID_COLS - 1);
      lo = KEY_MIN;
      hi = KEY_MAX;
      if (r > 0 && shadow[r-1][c] > lo) lo = shadow[r-1][c];
      if (c > 0 && shadow[r][c-1] > lo) lo = shadow[r][c-1];
      if (r < GRID_ROWS - 1 && shadow[r+1][c] < hi) hi = shadow[r+1][c];
      if (c < GRID_COLS - 1 && shadow[r][c+1] < hi) hi = shadow[r][c+1];
      v = (hi < lo) ? lo : lo + longint'($urandom) % (hi - lo + 1);
      send_write(r, c, v[31:0]);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_key();
      int p;
      int r;
      int c;
      p = $urandom_range(0, 99);
      r = $urandom_range(0, gen_rows - 1);
      c = $urandom_range(0, gen_cols - 1);
      if (p < 60) return shadow[r][c];
      if (p < 75) return shadow[r][c] + 1;
      if (p < 85) return shadow[r][c] - 1;
      if (p < 95) return $urandom();
      if (p < 97) return KEY_MIN;
      return KEY_MAX;
   endfunction

   task random_item();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) begin
         send_search(pick_key());
      end else if (p < 97) begin
         sorted_write();
      end else begin
         // out-of-order entry: the walk just follows whatever it meets
         send_write($urandom_range(0, GRID_ROWS - 1), $urandom_range(0, GRID_COLS - 1),
                    $urandom());
      end
   endtask

   initial begin
      logic signed [DATA_W-1:0] saved;
      int rows;
      int cols;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every entry is written before any search can reach it
      load_sorted();

      // corners, extremes, misses on the full region
      send_search(shadow[0][GRID_COLS-1]);
      send_search(shadow[GRID_ROWS-1][0]);
      send_search(shadow[0][0]);
      send_search(shadow[GRID_ROWS-1][GRID_COLS-1]);
      send_search(KEY_MIN);
      send_search(KEY_MAX);
      send_search(shadow[7][9] + 1);
      send_search(shadow[12][3] - 1);

      // out-of-order entry, then put back
      saved = shadow[3][12];
      send_write(3, 12, KEY_MAX);
      send_search(KEY_MAX);
      send_search(saved);
      send_write(3, 12, saved);

      // smallest region, empty regions, oversized region
      set_region(1, 1);
      send_search(shadow[0][0]);
      send_search(shadow[0][1]);
      set_region(0, 16);
      send_search(shadow[0][15]);
      set_region(16, 0);
      send_search(shadow[0][15]);
      set_region(31, 17);
      send_search(shadow[15][0]);
      send_search(shadow[15][15]);

      // writes to indexes with no register behind them change nothing
      drain();
      write_csr(CSR_UNMAPPED_HI, 5'd3);
      write_csr(CSR_UNMAPPED_LO, 5'd1);
      send_search(shadow[15][0]);

      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: begin rows = 16; cols = 16; end
            1: begin rows = 1; cols = 16; end
            2: begin rows = 16; cols = 1; end
            5: begin rows = 31; cols = 31; end
            7: begin rows = 0; cols = $urandom_range(1, 16); end
            default: begin
               rows = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(17, 31);
               cols = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(17, 31);
            end
         endcase
         set_region(rows, cols);
         no_idle = (phase == 2);
         if (phase == 4) begin
            // sink stalls while searches keep coming, so the block backs up
            rsp_hold_req = 1'b1;
            repeat (12) send_search(pick_key());
         end
         repeat (25) random_item();
      end

      no_idle = 1'b0;
      drain();
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/smss_pkg.sv
hw/rtl/smss_mem.sv
hw/rtl/smss_walk.sv
hw/rtl/sorted_matrix_staircase_search.sv
dv/sorted_matrix_staircase_search_test.sv
